// ===== design/vpq_pkg.sv =====
`default_nettype none
package vpq_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int NUM_CLASSES = 8;

    localparam int CLS_W     = $clog2(NUM_CLASSES);
    localparam int PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int RAM_AW    = CLS_W + PTR_W;
    localparam int RAM_DEPTH = NUM_CLASSES * (2 ** PTR_W);
    localparam int TICK_W    = 24;

    localparam logic [PTR_W-1:0]  LAST_SLOT  = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0]  FULL_COUNT = CNT_W'(QUEUE_DEPTH);
    localparam logic [15:0]       VLAN_ETHERTYPE   = 16'h8100;
    localparam logic [TICK_W-1:0] SLOT_TICKS_RESET = TICK_W'(100000);

    // request codes
    localparam logic [1:0] REQ_ARRIVAL = 2'd0;
    localparam logic [1:0] REQ_TICK    = 2'd1;
    localparam logic [1:0] REQ_EGRESS  = 2'd2;

    // result status codes
    localparam logic [2:0] ST_QUEUED  = 3'd0;
    localparam logic [2:0] ST_IGNORED = 3'd1;
    localparam logic [2:0] ST_DROPPED = 3'd2;
    localparam logic [2:0] ST_SENT    = 3'd3;
    localparam logic [2:0] ST_EMPTY   = 3'd4;
    localparam logic [2:0] ST_TICK    = 3'd5;

    typedef enum logic [1:0] {
        OP_ENQ    = 2'd0,
        OP_IGNORE = 2'd1,
        OP_TICK   = 2'd2,
        OP_SEND   = 2'd3
    } t_op;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] eth_type;
        logic [15:0] tag_control;
        logic [15:0] pkt_handle;
        logic [13:0] pkt_length;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [2:0]  send_class;
        logic [15:0] send_handle;
        logic [13:0] send_length;
        logic [2:0]  open_gate;
    } t_out_item;

    typedef struct packed {
        t_op              op;
        logic [CLS_W-1:0] cls;
        logic [15:0]      handle;
        logic [13:0]      length;
    } t_cmd;

    typedef struct packed {
        logic [15:0] handle;
        logic [13:0] length;
    } t_entry;

endpackage
`default_nettype wire

// ===== design/vlan_pcp_gated_priority_queues.sv =====
// Path: an accepted beat goes through the front command queue and the back-end
//   sequencer into the result queue; a send that finds a frame waits on the store read.
// Throughput: one beat per cycle for arrivals, ticks and empty sends while the
//   result queue has room; a send that pops a frame holds off the next command.
// Reset: synchronous, active low; pointers, counts, gate, timer and queues
//   clear at once, slot_ticks returns to 100000, the store is not cleared.
`default_nettype none
module vlan_pcp_gated_priority_queues (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       push,
    input  wire vpq_pkg::t_in_item          i_item,
    output logic                            full,
    output logic                            empty,
    input  wire logic                       pop,
    output vpq_pkg::t_out_item              o_res,
    input  wire logic                       i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire logic [vpq_pkg::TICK_W-1:0] i_cfg_data
);

    logic          cmd_valid;
    logic          cmd_pop;
    vpq_pkg::t_cmd cmd;

    assign o_cfg_ready = 1'b1;

    vpq_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_item      (i_item),
        .o_full      (full),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    vpq_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_res       (o_res)
    );

`ifndef SYNTHESIS
    a_pop_needs_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_pop |-> cmd_valid)
        else $error("command taken from an empty queue");

    a_full_has_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> cmd_valid)
        else $error("front queue full but no command offered");

    a_unsent_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_res.status != vpq_pkg::ST_SENT) |->
        (o_res.send_handle == '0 && o_res.send_length == '0))
        else $error("descriptor on a result that sent nothing");

    a_gate_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_res.status == vpq_pkg::ST_SENT) |->
        (o_res.send_class == o_res.open_gate))
        else $error("sent class differs from open gate");
`endif

endmodule
`default_nettype wire

// ===== design/vpq_ram.sv =====
`default_nettype none
module vpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// ===== design/vpq_front.sv =====
`default_nettype none
module vpq_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire vpq_pkg::t_in_item i_item,
    output logic                   o_full,
    output logic                   o_cmd_valid,
    output vpq_pkg::t_cmd          o_cmd,
    input  wire logic              i_cmd_pop
);

    vpq_pkg::t_cmd r_cq [2];
    logic          r_chead, n_chead;
    logic [1:0]    r_ccnt, n_ccnt;
    vpq_pkg::t_cmd cls_cmd;
    logic          accept;

    // classify the arriving request
    always_comb begin
        cls_cmd.op     = vpq_pkg::OP_IGNORE;
        cls_cmd.cls    = '0;
        cls_cmd.handle = i_item.pkt_handle;
        cls_cmd.length = i_item.pkt_length;
        unique case (i_item.req_type)
            vpq_pkg::REQ_ARRIVAL: begin
                if (i_item.eth_type == vpq_pkg::VLAN_ETHERTYPE) begin
                    cls_cmd.op  = vpq_pkg::OP_ENQ;
                    cls_cmd.cls = i_item.tag_control[15:13];
                end
            end
            vpq_pkg::REQ_TICK:   cls_cmd.op = vpq_pkg::OP_TICK;
            vpq_pkg::REQ_EGRESS: cls_cmd.op = vpq_pkg::OP_SEND;
            default:             cls_cmd.op = vpq_pkg::OP_IGNORE;
        endcase
    end

    assign o_full      = (r_ccnt == 2'd2);
    assign accept      = i_push && !o_full;
    assign o_cmd_valid = (r_ccnt != 2'd0);
    assign o_cmd       = r_cq[r_chead];

    always_comb begin
        n_chead = r_chead ^ i_cmd_pop;
        n_ccnt  = r_ccnt + 2'(accept) - 2'(i_cmd_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chead <= 1'b0;
            r_ccnt  <= 2'd0;
        end else begin
            r_chead <= n_chead;
            r_ccnt  <= n_ccnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cq[r_chead ^ r_ccnt[0]] <= cls_cmd;
        end
    end

endmodule
`default_nettype wire

// ===== design/vpq_back.sv =====
`default_nettype none
module vpq_back (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cmd_valid,
    input  wire vpq_pkg::t_cmd                i_cmd,
    output logic                              o_cmd_pop,
    input  wire logic                         i_cfg_valid,
    input  wire logic [vpq_pkg::TICK_W-1:0]   i_cfg_data,
    output logic                              o_empty,
    input  wire logic                         i_pop,
    output vpq_pkg::t_out_item                o_res
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } t_state;

    t_state                          r_state, n_state;
    logic [vpq_pkg::PTR_W-1:0]       r_head  [vpq_pkg::NUM_CLASSES];
    logic [vpq_pkg::PTR_W-1:0]       r_tail  [vpq_pkg::NUM_CLASSES];
    logic [vpq_pkg::CNT_W-1:0]       r_count [vpq_pkg::NUM_CLASSES];
    logic [vpq_pkg::CLS_W-1:0]       r_gate, n_gate;
    logic [vpq_pkg::TICK_W-1:0]      r_timer, n_timer;
    logic [vpq_pkg::TICK_W-1:0]      r_slot_ticks;
    logic [vpq_pkg::CLS_W-1:0]       r_pend_cls, n_pend_cls;

    vpq_pkg::t_out_item              r_rq [2];
    logic                            r_rhead;
    logic [1:0]                      r_rcnt;

    logic                            start;
    logic [vpq_pkg::CLS_W-1:0]       idx;
    logic [vpq_pkg::CNT_W-1:0]       cnt;
    logic [vpq_pkg::PTR_W-1:0]       head, tail;
    logic [vpq_pkg::TICK_W-1:0]      timer_inc;
    logic                            ptr_we;
    logic [vpq_pkg::PTR_W-1:0]       n_ptr;
    logic [vpq_pkg::CNT_W-1:0]       n_cnt;
    logic                            head_sel;
    logic                            ram_we, ram_re;
    logic [vpq_pkg::RAM_AW-1:0]      ram_waddr, ram_raddr;
    logic [$bits(vpq_pkg::t_entry)-1:0] ram_wdata, ram_rdata;
    vpq_pkg::t_entry                 wr_entry, rd_entry;
    logic                            res_push;
    vpq_pkg::t_out_item              res_data;
    logic                            res_pop;

    // one command in flight; room in the result queue is checked at start
    assign start     = (r_state == S_IDLE) && i_cmd_valid && (r_rcnt != 2'd2);
    assign o_cmd_pop = start;
    assign idx       = (i_cmd.op == vpq_pkg::OP_SEND) ? r_gate : i_cmd.cls;
    assign cnt       = r_count[idx];
    assign head      = r_head[idx];
    assign tail      = r_tail[idx];
    assign timer_inc = r_timer + vpq_pkg::TICK_W'(1);

    assign wr_entry.handle = i_cmd.handle;
    assign wr_entry.length = i_cmd.length;
    assign ram_wdata = wr_entry;
    assign ram_waddr = {idx, tail};
    assign ram_raddr = {idx, head};
    assign rd_entry  = vpq_pkg::t_entry'(ram_rdata);

    always_comb begin
        n_state    = r_state;
        n_gate     = r_gate;
        n_timer    = r_timer;
        n_pend_cls = r_pend_cls;
        ptr_we     = 1'b0;
        head_sel   = 1'b0;
        n_ptr      = '0;
        n_cnt      = cnt;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        res_push   = 1'b0;
        res_data   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    res_push           = 1'b1;
                    res_data.open_gate = r_gate;
                    unique case (i_cmd.op)
                        vpq_pkg::OP_ENQ: begin
                            res_data.send_class = i_cmd.cls;
                            if (cnt == vpq_pkg::FULL_COUNT) begin
                                res_data.status = vpq_pkg::ST_DROPPED;
                            end else begin
                                res_data.status = vpq_pkg::ST_QUEUED;
                                ram_we = 1'b1;
                                ptr_we = 1'b1;
                                n_ptr  = (tail == vpq_pkg::LAST_SLOT) ? '0
                                       : tail + vpq_pkg::PTR_W'(1);
                                n_cnt  = cnt + vpq_pkg::CNT_W'(1);
                            end
                        end
                        vpq_pkg::OP_IGNORE: begin
                            res_data.status = vpq_pkg::ST_IGNORED;
                        end
                        vpq_pkg::OP_TICK: begin
                            res_data.status = vpq_pkg::ST_TICK;
                            if (timer_inc >= r_slot_ticks) begin
                                n_timer = '0;
                                n_gate  = r_gate + vpq_pkg::CLS_W'(1);
                            end else begin
                                n_timer = timer_inc;
                            end
                            res_data.open_gate = n_gate;
                        end
                        vpq_pkg::OP_SEND: begin
                            if (cnt == '0) begin
                                res_data.status = vpq_pkg::ST_EMPTY;
                            end else begin
                                // hold the result until the head entry is read
                                res_push   = 1'b0;
                                ram_re     = 1'b1;
                                ptr_we     = 1'b1;
                                head_sel   = 1'b1;
                                n_ptr      = (head == vpq_pkg::LAST_SLOT) ? '0
                                           : head + vpq_pkg::PTR_W'(1);
                                n_cnt      = cnt - vpq_pkg::CNT_W'(1);
                                n_pend_cls = idx;
                                n_state    = S_READ;
                            end
                        end
                        default: res_data.status = vpq_pkg::ST_IGNORED;
                    endcase
                end
            end
            S_READ: begin
                res_push             = 1'b1;
                res_data.status      = vpq_pkg::ST_SENT;
                res_data.send_class  = r_pend_cls;
                res_data.send_handle = rd_entry.handle;
                res_data.send_length = rd_entry.length;
                res_data.open_gate   = r_gate;
                n_state              = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_gate       <= '0;
            r_timer      <= '0;
            r_slot_ticks <= vpq_pkg::SLOT_TICKS_RESET;
            for (int i = 0; i < vpq_pkg::NUM_CLASSES; i++) begin
                r_head[i]  <= '0;
                r_tail[i]  <= '0;
                r_count[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_gate  <= n_gate;
            r_timer <= n_timer;
            if (i_cfg_valid) begin
                r_slot_ticks <= i_cfg_data;
            end
            if (ptr_we) begin
                r_count[idx] <= n_cnt;
                if (head_sel) begin
                    r_head[idx] <= n_ptr;
                end else begin
                    r_tail[idx] <= n_ptr;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_cls <= n_pend_cls;
    end

    vpq_ram #(
        .WIDTH ($bits(vpq_pkg::t_entry)),
        .DEPTH (vpq_pkg::RAM_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // two-beat result queue
    assign o_empty = (r_rcnt == 2'd0);
    assign res_pop = i_pop && !o_empty;
    assign o_res   = r_rq[r_rhead];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rhead <= 1'b0;
            r_rcnt  <= 2'd0;
        end else begin
            r_rhead <= r_rhead ^ res_pop;
            r_rcnt  <= r_rcnt + 2'(res_push) - 2'(res_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_push) begin
            r_rq[r_rhead ^ r_rcnt[0]] <= res_data;
        end
    end

endmodule
`default_nettype wire

// ===== bench/vlan_pcp_gated_priority_queues_tb.sv =====
`timescale 1ns / 100ps

module vlan_pcp_gated_priority_queues_tb;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 600000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic push = 1'b0;
    logic pop = 1'b0;
    logic full;
    logic empty;
    vpq_pkg::t_in_item i_item = '0;
    vpq_pkg::t_out_item o_res;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [vpq_pkg::TICK_W-1:0] i_cfg_data = '0;

    vlan_pcp_gated_priority_queues u_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .push(push),
        .i_item(i_item),
        .full(full),
        .empty(empty),
        .pop(pop),
        .o_res(o_res),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data(i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // class queue shadow
    vpq_pkg::t_entry frame_store [vpq_pkg::NUM_CLASSES*vpq_pkg::QUEUE_DEPTH];
    int frame_rd [vpq_pkg::NUM_CLASSES];
    int frame_wr [vpq_pkg::NUM_CLASSES];
    int frame_cnt [vpq_pkg::NUM_CLASSES];
    logic [2:0] gate_now;
    logic [vpq_pkg::TICK_W-1:0] slot_elapsed;
    logic [vpq_pkg::TICK_W-1:0] slot_len;

    vpq_pkg::t_in_item requests_q [$];
    vpq_pkg::t_out_item expected_status_q [$];

    int unsigned mismatches = 0;
    int unsigned cycles = 0;

    function automatic vpq_pkg::t_out_item predict_gate_result(vpq_pkg::t_in_item it);
        vpq_pkg::t_out_item res;
        logic [2:0] cls;
        logic [vpq_pkg::TICK_W-1:0] next_elapsed;
        res = '0;
        res.status = vpq_pkg::ST_IGNORED;
        case (it.req_type)
            vpq_pkg::REQ_ARRIVAL: begin
                if (it.eth_type == vpq_pkg::VLAN_ETHERTYPE) begin
                    cls = it.tag_control[15:13];
                    res.send_class = cls;
                    if (frame_cnt[cls] >= vpq_pkg::QUEUE_DEPTH) begin
                        res.status = vpq_pkg::ST_DROPPED;
                    end else begin
                        frame_store[cls*vpq_pkg::QUEUE_DEPTH + frame_wr[cls]] =
                            {it.pkt_handle, it.pkt_length};
                        frame_wr[cls] = (frame_wr[cls] + 1) % vpq_pkg::QUEUE_DEPTH;
                        frame_cnt[cls]++;
                        res.status = vpq_pkg::ST_QUEUED;
                    end
                end
            end
            vpq_pkg::REQ_TICK: begin
                next_elapsed = slot_elapsed + 1'b1;
                // a zero slot length or one lowered below the timer advances at once
                if (next_elapsed >= slot_len) begin
                    next_elapsed = '0;
                    gate_now = gate_now + 1'b1;
                end
                slot_elapsed = next_elapsed;
                res.status = vpq_pkg::ST_TICK;
            end
            vpq_pkg::REQ_EGRESS: begin
                if (frame_cnt[gate_now] == 0) begin
                    res.status = vpq_pkg::ST_EMPTY;
                end else begin
                    {res.send_handle, res.send_length} =
                        frame_store[gate_now*vpq_pkg::QUEUE_DEPTH + frame_rd[gate_now]];
                    frame_rd[gate_now] = (frame_rd[gate_now] + 1) % vpq_pkg::QUEUE_DEPTH;
                    frame_cnt[gate_now]--;
                    res.send_class = gate_now;
                    res.status = vpq_pkg::ST_SENT;
                end
            end
            default: ;
        endcase
        res.open_gate = gate_now;
        return res;
    endfunction

    // mostly uniform waits, with occasional back-to-back runs
    function automatic int pick_gap(inout int burst_left);
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            burst_left = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 19);
    endfunction

    function automatic vpq_pkg::t_in_item make_request(int arrive_pct, int tick_pct,
                                                       int focus);
        vpq_pkg::t_in_item it;
        int r;
        r = $urandom_range(0, 99);
        it.eth_type = 16'($urandom);
        it.tag_control = 16'($urandom);
        it.pkt_handle = 16'($urandom);
        it.pkt_length = 14'($urandom);
        if (r < 3) begin
            it.req_type = REQ_UNUSED;
        end else if (r < 3 + arrive_pct) begin
            it.req_type = vpq_pkg::REQ_ARRIVAL;
            if ($urandom_range(0, 9) != 0)
                it.eth_type = vpq_pkg::VLAN_ETHERTYPE;
            else if ($urandom_range(0, 1) == 0)
                it.eth_type = vpq_pkg::VLAN_ETHERTYPE ^ (16'h1 << $urandom_range(0, 15));
            if (focus >= 0)
                it.tag_control[15:13] = 3'(focus + $urandom_range(0, 1));
            if ($urandom_range(0, 15) == 0)
                it.pkt_length = ($urandom_range(0, 1) == 0) ? 14'h0000 : 14'h3FFF;
        end else if (r < 3 + arrive_pct + tick_pct) begin
            it.req_type = vpq_pkg::REQ_TICK;
        end else begin
            it.req_type = vpq_pkg::REQ_EGRESS;
        end
        return it;
    endfunction

    // driver
    vpq_pkg::t_in_item cur_req;
    logic req_loaded = 1'b0;
    int push_gap = 0;
    int push_burst = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                expected_status_q.push_back(predict_gate_result(cur_req));
                req_loaded = 1'b0;
            end
            if (!req_loaded && requests_q.size() != 0) begin
                cur_req = requests_q.pop_front();
                push_gap = pick_gap(push_burst);
                req_loaded = 1'b1;
            end
            if (req_loaded && push_gap > 0) begin
                push_gap--;
                push <= 1'b0;
            end else begin
                push <= req_loaded;
            end
            i_item <= cur_req;
        end
    end

    // monitor
    vpq_pkg::t_out_item want;
    int pop_gap = 0;
    int pop_burst = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (expected_status_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected beat: status=%0d class=%0d handle=%h len=%h gate=%0d",
                                 o_res.status, o_res.send_class, o_res.send_handle,
                                 o_res.send_length, o_res.open_gate);
                end else begin
                    want = expected_status_q.pop_front();
                    if (o_res.status !== want.status || o_res.send_class !== want.send_class ||
                        o_res.send_handle !== want.send_handle ||
                        o_res.send_length !== want.send_length ||
                        o_res.open_gate !== want.open_gate) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch: exp status=%0d class=%0d handle=%h len=%h gate=%0d",
                                     want.status, want.send_class, want.send_handle,
                                     want.send_length, want.open_gate);
                            $display("          got status=%0d class=%0d handle=%h len=%h gate=%0d",
                                     o_res.status, o_res.send_class, o_res.send_handle,
                                     o_res.send_length, o_res.open_gate);
                        end
                    end
                end
                pop_gap = pick_gap(pop_burst);
            end
            if (pop_gap > 0) begin
                pop_gap--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic add_request(input logic [1:0] req, input logic [15:0] etype,
                               input logic [15:0] tci, input logic [15:0] handle,
                               input logic [13:0] len);
        vpq_pkg::t_in_item it;
        it.req_type = req;
        it.eth_type = etype;
        it.tag_control = tci;
        it.pkt_handle = handle;
        it.pkt_length = len;
        requests_q.push_back(it);
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (requests_q.size() != 0 || req_loaded || expected_status_q.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_slot_ticks(input logic [vpq_pkg::TICK_W-1:0] ticks);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= ticks;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        slot_len = ticks;
    endtask

    task automatic run_phase(input logic [vpq_pkg::TICK_W-1:0] ticks, input int n,
                             input int arrive_pct, input int tick_pct, input int focus);
        wait_idle();
        set_slot_ticks(ticks);
        repeat (n) requests_q.push_back(make_request(arrive_pct, tick_pct, focus));
    endtask

    initial begin
        for (int c = 0; c < vpq_pkg::NUM_CLASSES; c++) begin
            frame_rd[c] = 0;
            frame_wr[c] = 0;
            frame_cnt[c] = 0;
        end
        gate_now = '0;
        slot_elapsed = '0;
        slot_len = vpq_pkg::SLOT_TICKS_RESET;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // field extremes, every class, near-miss ethertypes, FIFO order, empty gate
        add_request(vpq_pkg::REQ_ARRIVAL, vpq_pkg::VLAN_ETHERTYPE, 16'h0000, 16'h0000,
                    14'h0000);
        add_request(vpq_pkg::REQ_ARRIVAL, vpq_pkg::VLAN_ETHERTYPE, 16'hFFFF, 16'hFFFF,
                    14'h3FFF);
        for (int c = 1; c < 7; c++)
            add_request(vpq_pkg::REQ_ARRIVAL, vpq_pkg::VLAN_ETHERTYPE, {3'(c), 13'h0AAA},
                        16'($urandom), 14'($urandom));
        add_request(vpq_pkg::REQ_ARRIVAL, 16'h8101, 16'h2000, 16'h1234, 14'h0055);
        add_request(vpq_pkg::REQ_ARRIVAL, 16'h0100, 16'h4000, 16'h4321, 14'h0155);
        add_request(vpq_pkg::REQ_ARRIVAL, 16'hFFFF, 16'h6000, 16'hFFFF, 14'h3FFF);
        add_request(vpq_pkg::REQ_ARRIVAL, 16'h0000, 16'h0000, 16'h0000, 14'h0000);
        add_request(REQ_UNUSED, vpq_pkg::VLAN_ETHERTYPE, 16'hE000, 16'hBEEF, 14'h0123);
        add_request(vpq_pkg::REQ_EGRESS, 16'hFFFF, 16'hFFFF, 16'hFFFF, 14'h3FFF);
        add_request(vpq_pkg::REQ_EGRESS, 16'h0000, 16'h0000, 16'h0000, 14'h0000);
        add_request(vpq_pkg::REQ_ARRIVAL, vpq_pkg::VLAN_ETHERTYPE, 16'h1FFF, 16'hA5A5,
                    14'h2AAA);
        add_request(vpq_pkg::REQ_ARRIVAL, vpq_pkg::VLAN_ETHERTYPE, 16'h0000, 16'h5A5A,
                    14'h1555);
        add_request(vpq_pkg::REQ_EGRESS, vpq_pkg::VLAN_ETHERTYPE, 16'hFFFF, 16'h0000,
                    14'h0000);
        add_request(vpq_pkg::REQ_EGRESS, vpq_pkg::VLAN_ETHERTYPE, 16'hFFFF, 16'h0000,
                    14'h0000);
        add_request(vpq_pkg::REQ_EGRESS, vpq_pkg::VLAN_ETHERTYPE, 16'hFFFF, 16'h0000,
                    14'h0000);
        add_request(vpq_pkg::REQ_TICK, vpq_pkg::VLAN_ETHERTYPE, 16'hFFFF, 16'hFFFF,
                    14'h3FFF);
        add_request(vpq_pkg::REQ_TICK, 16'h0000, 16'h0000, 16'h0000, 14'h0000);

        // zero slot length: gate moves on every tick
        run_phase(24'd0, 200, 45, 25, -1);
        run_phase(24'd1, 200, 45, 25, -1);
        // pile arrivals onto two classes until they overflow
        run_phase(24'd3, 300, 70, 15, $urandom_range(0, 7));
        // longest slot holds the gate; the timer keeps counting
        run_phase(24'hFFFFFF, 200, 40, 40, -1);
        // lowered below the running timer: next tick advances the gate
        run_phase(24'd5, 300, 10, 40, -1);
        repeat (4) run_phase(24'($urandom_range(1, 20)), 100, 40, 25, -1);

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== vlan_pcp_gated_priority_queues.f =====
design/vpq_pkg.sv
design/vpq_ram.sv
design/vpq_front.sv
design/vpq_back.sv
design/vlan_pcp_gated_priority_queues.sv
bench/vlan_pcp_gated_priority_queues_tb.sv
